// ===== rtl/fbc_pkg.sv =====
// fbc_pkg: shared widths, register indexes, types and plane helpers for the
// frustum box cull block. No dependencies.
package fbc_pkg;

    // field widths
    localparam int COORD_W    = 16;
    localparam int EXT_W      = 8;
    localparam int HGT_W      = 10;
    localparam int COEF_W     = 16;
    localparam int MAT_W      = 64;
    localparam int MAT_COLS   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PLANES     = 6;
    localparam int AXES       = 3;
    localparam int PLANE_W    = 3;

    // derived arithmetic widths: plane terms, corners, products, plane sum
    localparam int NRM_W  = COEF_W + 1;
    localparam int CRN_W  = COORD_W + 1;
    localparam int PROD_W = NRM_W + CRN_W;
    localparam int ACC_W  = PROD_W + 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CULL_EN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_COL0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_COL1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_COL2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAT_COL3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENT_XZ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd6;

    // reset values
    localparam logic [EXT_W-1:0] EXT_RESET = 8'd15;
    localparam logic [HGT_W-1:0] HGT_RESET = 10'd24;

    // plane code reported when no plane rejects the box
    localparam logic [PLANE_W-1:0] PLANE_VISIBLE = 3'd6;

    typedef logic signed [NRM_W-1:0]  t_nrm;
    typedef logic signed [CRN_W-1:0]  t_crn;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // one clip plane: normal and offset, Q5.12
    typedef struct packed {
        t_nrm nx;
        t_nrm ny;
        t_nrm nz;
        t_nrm d;
    } t_plane;

    // box geometry and mode from configuration
    typedef struct packed {
        logic             cull_en;
        logic [EXT_W-1:0] ext_xz;
        logic [HGT_W-1:0] height;
    } t_geom;

    // matrix entry of one column at a row, sign extended
    function automatic t_nrm mat_entry(logic [MAT_W-1:0] col, int row);
        logic signed [COEF_W-1:0] raw;
        raw = $signed(col[COEF_W*row +: COEF_W]);
        return t_nrm'(raw);
    endfunction

    // plane k: row 3 plus or minus row k/2
    function automatic t_plane plane_coef(logic [MAT_COLS-1:0][MAT_W-1:0] cols, int k);
        t_plane p;
        int     axis;
        logic   minus;
        axis  = k >> 1;
        minus = k[0];
        if (minus) begin
            p.nx = mat_entry(cols[0], 3) - mat_entry(cols[0], axis);
            p.ny = mat_entry(cols[1], 3) - mat_entry(cols[1], axis);
            p.nz = mat_entry(cols[2], 3) - mat_entry(cols[2], axis);
            p.d  = mat_entry(cols[3], 3) - mat_entry(cols[3], axis);
        end else begin
            p.nx = mat_entry(cols[0], 3) + mat_entry(cols[0], axis);
            p.ny = mat_entry(cols[1], 3) + mat_entry(cols[1], axis);
            p.nz = mat_entry(cols[2], 3) + mat_entry(cols[2], axis);
            p.d  = mat_entry(cols[3], 3) + mat_entry(cols[3], axis);
        end
        return p;
    endfunction

    // normal component along one axis
    function automatic t_nrm plane_nrm(t_plane p, int c);
        t_nrm n;
        case (c)
            0:       n = p.nx;
            1:       n = p.ny;
            default: n = p.nz;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/fbc_if.sv =====
// fbc_if: valid/ready channel interfaces of the frustum box cull block:
// box items in, results out, configuration writes. Uses fbc_pkg.

// box item channel
interface fbc_box_if;
    logic                                valid;
    logic                                ready;
    logic signed [fbc_pkg::COORD_W-1:0]  origin_x;
    logic signed [fbc_pkg::COORD_W-1:0]  origin_y;
    logic signed [fbc_pkg::COORD_W-1:0]  origin_z;
    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    input ready);
    modport sink   (input valid, input origin_x, input origin_y, input origin_z,
                    output ready);
endinterface

// result item channel
interface fbc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          visible;
    logic [fbc_pkg::PLANE_W-1:0]   culled_by_plane;
    modport source (output valid, output visible, output culled_by_plane, input ready);
    modport sink   (input valid, input visible, input culled_by_plane, output ready);
endinterface

// configuration write channel
interface fbc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fbc_pkg::CFG_IDX_W-1:0]    index;
    logic [fbc_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/frustum_box_cull.sv =====
// frustum_box_cull: top level of the frustum box cull block, pipeline
// control and assertions. Uses fbc_pkg, fbc_if, fbc_cfg, fbc_mul, fbc_eval.
//
// Usage
//   i_box carries one box item (minimum corner origin_x/y/z); o_res returns
//   one result item per box: visible and the first rejecting plane (0..5),
//   or 6 when visible. i_cfg writes the registers: 0 cull enable, 1..4 the
//   matrix columns, 5 box extent along x and z, 6 box height; index 7 is
//   ignored. Write the registers only while no box is in flight.
//   Matrix writes go to the matrix register first; the plane registers are then loaded from it.
//   Flow: a box accepted at one clock edge is loaded into the corner
//   register at that edge, then passes through the product register and the
//   result register to o_res. Throughput: one box per cycle while o_res.ready
//   is high, through the three-stage register pipeline, with the
//   18 plane-times-corner multipliers in the middle stage.
//   Stall: when o_res.ready is low the stages fill up and i_box.ready falls
//   once all three hold items; nothing is dropped.
//   Reset (i_rst_n low, synchronous): pipeline emptied, cull enable 1,
//   matrix 0, extent 15, height 24; no box is taken during reset.
module frustum_box_cull (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fbc_cfg_if.sink       i_cfg,
    fbc_box_if.sink       i_box,
    fbc_res_if.source     o_res
);
    import fbc_pkg::*;

    t_geom                          w_geom;
    t_plane [PLANES-1:0]            w_planes;
    t_prod [PLANES-1:0][AXES-1:0]   w_prod;
    logic                           r_v0;
    logic                           r_v1;
    logic                           r_v2;
    logic                           w_rdy0;
    logic                           w_rdy1;
    logic                           w_rdy2;

    // stage moves when empty or when the next one moves
    assign w_rdy2      = !r_v2 || o_res.ready;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign w_rdy0      = !r_v0 || w_rdy1;
    assign i_box.ready = i_rst_n && w_rdy0;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_box.valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // configuration and planes
    fbc_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_geom   (w_geom),
        .o_planes (w_planes)
    );

    // corners and products
    fbc_mul u_mul (
        .i_clk      (i_clk),
        .i_load     (w_rdy0),
        .i_adv      (w_rdy1),
        .i_origin_x (i_box.origin_x),
        .i_origin_y (i_box.origin_y),
        .i_origin_z (i_box.origin_z),
        .i_geom     (w_geom),
        .i_planes   (w_planes),
        .o_prod     (w_prod)
    );

    // plane tests and result register
    fbc_eval u_eval (
        .i_clk     (i_clk),
        .i_adv     (w_rdy2),
        .i_prod    (w_prod),
        .i_planes  (w_planes),
        .i_cull_en (w_geom.cull_en),
        .o_visible (o_res.visible),
        .o_plane   (o_res.culled_by_plane)
    );

    assign o_res.valid = r_v2;

`ifndef SYNTHESIS
    // visible flag agrees with the plane code
    a_vis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.visible == (o_res.culled_by_plane == PLANE_VISIBLE)))
        else $error("visible flag and plane code disagree");

    // with culling off every box is visible
    a_cull_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !w_geom.cull_en) |-> o_res.visible)
        else $error("box culled while culling disabled");

    // a product stage item is held while the result stage is blocked
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_rdy2) |=> r_v1)
        else $error("item lost in product stage during stall");
`endif

endmodule

// ===== rtl/fbc_cfg.sv =====
// fbc_cfg: configuration registers and the six registered clip planes
// derived from the matrix. Uses fbc_pkg and fbc_cfg_if.
module fbc_cfg (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    fbc_cfg_if.sink                                  i_cfg,
    output fbc_pkg::t_geom                           o_geom,
    output fbc_pkg::t_plane [fbc_pkg::PLANES-1:0]    o_planes
);
    import fbc_pkg::*;

    logic                               r_cull_en;
    logic [MAT_COLS-1:0][MAT_W-1:0]     r_mat;
    logic [EXT_W-1:0]                   r_ext_xz;
    logic [HGT_W-1:0]                   r_height;
    t_plane [PLANES-1:0]                r_planes;
    t_plane [PLANES-1:0]                n_planes;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull_en <= 1'b1;
            r_mat     <= '0;
            r_ext_xz  <= EXT_RESET;
            r_height  <= HGT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CULL_EN:    r_cull_en <= i_cfg.data[0];
                REG_MAT_COL0:   r_mat[0]  <= i_cfg.data[MAT_W-1:0];
                REG_MAT_COL1:   r_mat[1]  <= i_cfg.data[MAT_W-1:0];
                REG_MAT_COL2:   r_mat[2]  <= i_cfg.data[MAT_W-1:0];
                REG_MAT_COL3:   r_mat[3]  <= i_cfg.data[MAT_W-1:0];
                REG_EXTENT_XZ:  r_ext_xz  <= i_cfg.data[EXT_W-1:0];
                REG_BOX_HEIGHT: r_height  <= i_cfg.data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // plane sums from the matrix rows
    always_comb begin
        for (int k = 0; k < PLANES; k++) begin
            n_planes[k] = plane_coef(r_mat, k);
        end
    end

    // planes follow the matrix in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else begin
            r_planes <= n_planes;
        end
    end

    assign o_geom.cull_en = r_cull_en;
    assign o_geom.ext_xz  = r_ext_xz;
    assign o_geom.height  = r_height;
    assign o_planes       = r_planes;

endmodule

// ===== rtl/fbc_mul.sv =====
// fbc_mul: box corner register and the registered products of every plane
// normal with its furthest corner coordinate. Uses fbc_pkg.
module fbc_mul (
    input  logic                                                      i_clk,
    input  logic                                                      i_load,
    input  logic                                                      i_adv,
    input  logic signed [fbc_pkg::COORD_W-1:0]                        i_origin_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]                        i_origin_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]                        i_origin_z,
    input  fbc_pkg::t_geom                                            i_geom,
    input  fbc_pkg::t_plane [fbc_pkg::PLANES-1:0]                     i_planes,
    output fbc_pkg::t_prod [fbc_pkg::PLANES-1:0][fbc_pkg::AXES-1:0]   o_prod
);
    import fbc_pkg::*;

    t_crn                          r_lo [AXES];
    t_crn                          r_hi [AXES];
    t_crn                          n_lo [AXES];
    t_crn                          n_hi [AXES];
    t_prod [PLANES-1:0][AXES-1:0]  r_prod;
    t_prod [PLANES-1:0][AXES-1:0]  n_prod;

    // min and max corners of the incoming box
    always_comb begin
        n_lo[0] = t_crn'(i_origin_x);
        n_lo[1] = t_crn'(i_origin_y);
        n_lo[2] = t_crn'(i_origin_z);
        n_hi[0] = n_lo[0] + t_crn'(i_geom.ext_xz);
        n_hi[1] = n_lo[1] + t_crn'(i_geom.height);
        n_hi[2] = n_lo[2] + t_crn'(i_geom.ext_xz);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    // furthest corner along each normal, one multiplier per term
    always_comb begin
        for (int k = 0; k < PLANES; k++) begin
            for (int c = 0; c < AXES; c++) begin
                t_nrm n;
                t_crn p;
                n = plane_nrm(i_planes[k], c);
                p = (n >= 0) ? r_hi[c] : r_lo[c];
                n_prod[k][c] = t_prod'(n) * t_prod'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/fbc_eval.sv =====
// fbc_eval: per-plane sum and sign test, first rejecting plane and the
// registered result. Uses fbc_pkg.
module fbc_eval (
    input  logic                                                      i_clk,
    input  logic                                                      i_adv,
    input  fbc_pkg::t_prod [fbc_pkg::PLANES-1:0][fbc_pkg::AXES-1:0]   i_prod,
    input  fbc_pkg::t_plane [fbc_pkg::PLANES-1:0]                     i_planes,
    input  logic                                                      i_cull_en,
    output logic                                                      o_visible,
    output logic [fbc_pkg::PLANE_W-1:0]                               o_plane
);
    import fbc_pkg::*;

    logic [PLANES-1:0]   w_out;
    logic [PLANE_W-1:0]  n_plane;
    logic [PLANE_W-1:0]  r_plane;
    logic                r_visible;

    // dot product plus offset, negative means outside
    always_comb begin
        for (int k = 0; k < PLANES; k++) begin
            t_acc acc;
            acc = t_acc'($signed(i_prod[k][0])) + t_acc'($signed(i_prod[k][1]))
                + t_acc'($signed(i_prod[k][2])) + t_acc'(i_planes[k].d);
            w_out[k] = acc[ACC_W-1];
        end
    end

    // lowest rejecting plane wins
    always_comb begin
        n_plane = PLANE_VISIBLE;
        if (i_cull_en) begin
            for (int k = PLANES - 1; k >= 0; k--) begin
                if (w_out[k]) begin
                    n_plane = PLANE_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_plane   <= n_plane;
            r_visible <= (n_plane == PLANE_VISIBLE);
        end
    end

    assign o_visible = r_visible;
    assign o_plane   = r_plane;

endmodule

// ===== tb/tb_frustum_box_cull.sv =====
`timescale 1ns / 100ps
// tb_frustum_box_cull: self-checking bench for frustum_box_cull, a directed table followed
// by randomised register settings, each result checked against a typed-in table result
// or an in-bench plane-test model. Depends on fbc_pkg, fbc_if and the frustum_box_cull rtl.
module tb_frustum_box_cull;
    import fbc_pkg::*;

    localparam int PIPE_LAT   = 3;
    localparam int RESET_CYC  = 6;
    localparam int RAND_BOXES = 1400;
    localparam int LIMIT_CYC  = 400000;
    localparam int REPORT_MAX = 10;
    localparam int DIR_ROWS   = 37;
    localparam int W_ROW      = 3;
    localparam int TRANS_COL  = 3;
    localparam int ENTRIES    = MAT_W / COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd7;
    localparam logic [PLANE_W-1:0]   PLANE_LEFT    = 3'd0;
    localparam logic [COEF_W-1:0]    Q12_ONE       = 16'h1000;
    localparam logic [COEF_W-1:0]    Q12_MINUS_ONE = 16'hF000;

    typedef struct packed {
        logic               visible;
        logic [PLANE_W-1:0] plane;
    } t_cull_res;

    // result typed into the table, or left to the predictor when known is low
    typedef struct packed {
        logic      known;
        t_cull_res res;
    } t_known_res;

    localparam t_known_res BY_PREDICT   = '0;
    localparam t_known_res WANT_VISIBLE = '{known: 1'b1,
                                            res: '{visible: 1'b1, plane: PLANE_VISIBLE}};
    localparam t_known_res WANT_LEFT    = '{known: 1'b1,
                                            res: '{visible: 1'b0, plane: PLANE_LEFT}};

    typedef enum logic {ROW_CFG, ROW_BOX} t_row_op;

    typedef struct {
        t_row_op                   op;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     data;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        t_known_res                want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    fbc_cfg_if cfg_ch ();
    fbc_box_if box_ch ();
    fbc_res_if res_ch ();

    frustum_box_cull uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_box   (box_ch),
        .o_res   (res_ch)
    );

    // register copy used by the predictor
    logic                           sh_cull_en;
    logic [MAT_COLS-1:0][MAT_W-1:0] sh_mat;
    logic [EXT_W-1:0]               sh_ext;
    logic [HGT_W-1:0]               sh_hgt;

    t_cull_res   verdict_q [$];
    t_cull_res   want_res;
    t_known_res  box_known;
    int          outstanding = 0;
    int          fail_cnt    = 0;
    int          result_cnt  = 0;
    int          culled_cnt  = 0;
    int          write_cnt   = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned sink_wait   = 0;
    int unsigned sink_next;
    bit          src_gaps;
    bit          sink_stalls;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // idle length: mostly short, a few long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(2, 1);
        if (r < 95) return $urandom_range(6, 3);
        return $urandom_range(30, 10);
    endfunction

    // signed q4.12 matrix entry from the register copy
    function automatic longint q12_at(int col, int row);
        logic signed [COEF_W-1:0] raw;
        raw = sh_mat[col][COEF_W*row +: COEF_W];
        return longint'(raw);
    endfunction

    // six clip planes in order, culled at the first one with the far corner behind it
    function automatic t_cull_res judge_box(logic signed [COORD_W-1:0] ox, oy, oz);
        t_cull_res r;
        longint    lo [AXES];
        longint    hi [AXES];
        longint    acc;
        longint    nrm;
        int        axis;
        r.visible = 1'b1;
        r.plane   = PLANE_VISIBLE;
        lo[0] = ox;
        lo[1] = oy;
        lo[2] = oz;
        hi[0] = lo[0] + longint'(sh_ext);
        hi[1] = lo[1] + longint'(sh_hgt);
        hi[2] = lo[2] + longint'(sh_ext);
        if (sh_cull_en) begin
            for (int k = 0; k < PLANES && r.visible; k++) begin
                axis = k >> 1;
                if (k % 2 == 1) acc = q12_at(TRANS_COL, W_ROW) - q12_at(TRANS_COL, axis);
                else acc = q12_at(TRANS_COL, W_ROW) + q12_at(TRANS_COL, axis);
                for (int c = 0; c < AXES; c++) begin
                    if (k % 2 == 1) nrm = q12_at(c, W_ROW) - q12_at(c, axis);
                    else nrm = q12_at(c, W_ROW) + q12_at(c, axis);
                    // zero component counts as positive: max corner
                    acc += nrm * ((nrm >= 0) ? hi[c] : lo[c]);
                end
                if (acc < 0) begin
                    r.visible = 1'b0;
                    r.plane   = PLANE_W'(k);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // matrix column, full range or moderate entries
    function automatic logic [MAT_W-1:0] rand_column(bit mild);
        logic [MAT_W-1:0] col;
        int               e;
        for (int r = 0; r < ENTRIES; r++) begin
            if (mild) e = int'($urandom_range(12288)) - 6144;
            else e = int'($urandom_range(65535));
            col[COEF_W*r +: COEF_W] = e[COEF_W-1:0];
        end
        return col;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(bit near);
        int v;
        if (near) v = int'($urandom_range(1200)) - 600;
        else v = int'($urandom_range(65535)) - 32768;
        return COORD_W'(v);
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row r;
        r      = '{op: ROW_CFG, idx: idx, data: data, x: '0, y: '0, z: '0, want: BY_PREDICT};
        return r;
    endfunction

    // table coordinates are written as plain integers and narrowed here
    function automatic t_row box_row(int x, int y, int z, t_known_res want);
        t_row r;
        r      = '{op: ROW_BOX, idx: '0, data: '0, x: COORD_W'(x), y: COORD_W'(y),
                   z: COORD_W'(z), want: want};
        return r;
    endfunction

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) $display("%0t %s", $time, msg);
    endtask

    // present one box item and hold it until taken
    task automatic send_box(input logic signed [COORD_W-1:0] x, y, z, input t_known_res k);
        if (src_gaps && $urandom_range(99) < 25) begin
            box_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        box_ch.valid    <= 1'b1;
        box_ch.origin_x <= x;
        box_ch.origin_y <= y;
        box_ch.origin_z <= z;
        box_known       <= k;
        do @(posedge i_clk); while (!(box_ch.valid && box_ch.ready));
    endtask

    // stop sending and wait until every pending result is back
    task automatic settle();
        box_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        write_cnt++;
        @(posedge i_clk);
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        if (sink_wait != 0) sink_next = sink_wait - 1;
        else if (sink_stalls && $urandom_range(99) < 20) sink_next = gap_len();
        else sink_next = 0;
        sink_wait = sink_next;
        res_ch.ready <= (sink_next == 0);
    end

    // register copy, expected results and result checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sh_cull_en = 1'b1;
            sh_mat     = '0;
            sh_ext     = EXT_RESET;
            sh_hgt     = HGT_RESET;
            verdict_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_CULL_EN:    sh_cull_en = cfg_ch.data[0];
                    REG_MAT_COL0:   sh_mat[0]  = cfg_ch.data;
                    REG_MAT_COL1:   sh_mat[1]  = cfg_ch.data;
                    REG_MAT_COL2:   sh_mat[2]  = cfg_ch.data;
                    REG_MAT_COL3:   sh_mat[3]  = cfg_ch.data;
                    REG_EXTENT_XZ:  sh_ext     = cfg_ch.data[EXT_W-1:0];
                    REG_BOX_HEIGHT: sh_hgt     = cfg_ch.data[HGT_W-1:0];
                    default: ;
                endcase
            end
            if (box_ch.valid && box_ch.ready) begin
                if (box_known.known) verdict_q.push_back(box_known.res);
                else verdict_q.push_back(judge_box(box_ch.origin_x, box_ch.origin_y,
                                                   box_ch.origin_z));
            end
            if (res_ch.valid && res_ch.ready) begin
                result_cnt++;
                if (res_ch.visible === 1'b0) culled_cnt++;
                if (verdict_q.size() == 0) begin
                    note_fail($sformatf("result with no box pending: visible %0b plane %0d",
                                        res_ch.visible, res_ch.culled_by_plane));
                end else begin
                    want_res = verdict_q.pop_front();
                    if (res_ch.visible !== want_res.visible
                            || res_ch.culled_by_plane !== want_res.plane)
                        note_fail($sformatf(
                            "result %0d: visible exp %0b got %0b, plane exp %0d got %0d",
                            result_cnt, want_res.visible, res_ch.visible,
                            want_res.plane, res_ch.culled_by_plane));
                end
            end
            outstanding <= verdict_q.size();
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYC) begin
            $display("timed out after %0d cycles with %0d results pending",
                     cycle_cnt, verdict_q.size());
            $display("frustum_box_cull: mismatch");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row                  dir_rows [DIR_ROWS];
        logic [CFG_DATA_W-1:0] word;
        int                    n_boxes;
        int                    pause_at;
        int                    sent;
        int                    phase;
        int                    pick;
        bit                    mild;
        bit                    near;

        i_rst_n         = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        box_ch.valid    = 1'b0;
        box_ch.origin_x = '0;
        box_ch.origin_y = '0;
        box_ch.origin_z = '0;
        res_ch.ready    = 1'b0;
        box_known       = BY_PREDICT;
        src_gaps        = 1'b1;
        sink_stalls     = 1'b1;

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows = '{
            // reset state: zero matrix, every plane passes
            box_row(-32768, -32768, -32768, WANT_VISIBLE),
            box_row(32767, 32767, 32767, WANT_VISIBLE),
            // culling off, wide value keeps bit 0 only
            cfg_row(REG_CULL_EN, 64'h2),
            cfg_row(REG_MAT_COL3, {Q12_MINUS_ONE, 48'h0}),
            box_row(0, 0, 0, WANT_VISIBLE),
            box_row(-32768, 32767, -32768, WANT_VISIBLE),
            // zero normals with negative offset reject at the first plane
            cfg_row(REG_CULL_EN, '1),
            box_row(0, 0, 0, WANT_LEFT),
            box_row(32767, -32768, 5, WANT_LEFT),
            // unit orthographic matrix
            cfg_row(REG_MAT_COL0, {48'h0, Q12_ONE}),
            cfg_row(REG_MAT_COL1, {32'h0, Q12_ONE, 16'h0}),
            cfg_row(REG_MAT_COL2, {16'h0, Q12_ONE, 32'h0}),
            cfg_row(REG_MAT_COL3, {Q12_ONE, 48'h0}),
            box_row(-8, -12, -8, BY_PREDICT),
            box_row(100, 0, 0, BY_PREDICT),
            box_row(-100, 0, 0, BY_PREDICT),
            box_row(0, -30, 0, BY_PREDICT),
            box_row(0, 0, 50, BY_PREDICT),
            box_row(0, 40, 0, BY_PREDICT),
            // largest box, over-wide values truncated
            cfg_row(REG_EXTENT_XZ, 64'h1FF),
            cfg_row(REG_BOX_HEIGHT, 64'hFFFF),
            box_row(-200, -1000, -200, BY_PREDICT),
            box_row(32767, 32767, 32767, BY_PREDICT),
            // flat point box, touching the planes
            cfg_row(REG_EXTENT_XZ, 64'h0),
            cfg_row(REG_BOX_HEIGHT, 64'h0),
            box_row(-32768, -32768, -32768, BY_PREDICT),
            box_row(1, 1, 1, BY_PREDICT),
            // write to the unused index changes nothing
            cfg_row(REG_UNUSED, '1),
            box_row(1, 1, 1, BY_PREDICT),
            // extreme matrix entries
            cfg_row(REG_MAT_COL0, 64'h8000_7FFF_8000_7FFF),
            cfg_row(REG_MAT_COL1, 64'h7FFF_8000_7FFF_8000),
            cfg_row(REG_MAT_COL2, 64'h8000_8000_7FFF_7FFF),
            cfg_row(REG_MAT_COL3, 64'h7FFF_7FFF_8000_8000),
            box_row(-32768, -32768, -32768, BY_PREDICT),
            box_row(32767, 32767, 32767, BY_PREDICT),
            box_row(-32768, 32767, 0, BY_PREDICT),
            box_row(0, -1, -1, BY_PREDICT)
        };

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_box(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].want);
            end
        end

        // random settings, each followed by a burst of boxes
        sent  = 0;
        phase = 0;
        while (sent < RAND_BOXES) begin
            settle();
            mild = ($urandom_range(99) < 70);

            word    = rand_word();
            word[0] = ($urandom_range(99) < 85);
            write_reg(REG_CULL_EN, word);
            write_reg(REG_MAT_COL0, rand_column(mild));
            write_reg(REG_MAT_COL1, rand_column(mild));
            write_reg(REG_MAT_COL2, rand_column(mild));
            write_reg(REG_MAT_COL3, rand_column(mild));

            word = rand_word();
            pick = $urandom_range(9);
            if (pick == 0) word[EXT_W-1:0] = '0;
            else if (pick == 1) word[EXT_W-1:0] = '1;
            write_reg(REG_EXTENT_XZ, word);

            word = rand_word();
            pick = $urandom_range(9);
            if (pick == 0) word[HGT_W-1:0] = '0;
            else if (pick == 1) word[HGT_W-1:0] = '1;
            write_reg(REG_BOX_HEIGHT, word);

            if ($urandom_range(4) == 0) write_reg(REG_UNUSED, rand_word());

            src_gaps    <= ($urandom_range(3) != 0);
            sink_stalls <= ($urandom_range(3) != 0);
            n_boxes = $urandom_range(140, 60);
            // sender drains the pipe once mid-burst, always in the first burst
            if (phase == 0 || $urandom_range(2) == 0) pause_at = $urandom_range(n_boxes - 1);
            else pause_at = -1;

            for (int i = 0; i < n_boxes; i++) begin
                if (i == pause_at) settle();
                near = ($urandom_range(99) < 70);
                send_box(rand_coord(near), rand_coord(near), rand_coord(near), BY_PREDICT);
            end
            sent  += n_boxes;
            phase++;
        end

        settle();
        $display("checked %0d results (%0d culled) from a %0d-row table and %0d random boxes",
                 result_cnt, culled_cnt, DIR_ROWS, sent);
        $display("%0d register writes across %0d random settings", write_cnt, phase);
        if (fail_cnt == 0) begin
            $display("frustum_box_cull: match");
        end else begin
            $display("%0d failures", fail_cnt);
            $display("frustum_box_cull: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fbc_pkg.sv
rtl/fbc_if.sv
rtl/fbc_cfg.sv
rtl/fbc_mul.sv
rtl/fbc_eval.sv
rtl/frustum_box_cull.sv
tb/tb_frustum_box_cull.sv
